[rtl/rtpd_pkg.sv]
`default_nettype none
package rtpd_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // parser position within a packet
    localparam logic [3:0] POS_IDLE    = 4'd0;
    localparam logic [3:0] POS_HDR_END = 4'd11;
    localparam logic [3:0] POS_SKIP    = 4'd12;
    localparam logic [3:0] POS_NAL     = 4'd13;
    localparam logic [3:0] POS_FU      = 4'd14;
    localparam logic [3:0] POS_PAYLOAD = 4'd15;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [4:0] FU_A_TYPE   = 5'd28;

    localparam logic [6:0] PT_RESET  = 7'd96;
    localparam logic [7:0] EXT_RESET = 8'd16;

    localparam logic CFG_PAYLOAD_TYPE = 1'b0;
    localparam logic CFG_EXT_SKIP     = 1'b1;

    localparam logic [2:0] ST_FRAME_DONE = 3'd0;
    localparam logic [2:0] ST_FRAME_CONT = 3'd1;
    localparam logic [2:0] ST_BAD_VER    = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ST_SEQ_GAP    = 3'd4;
    localparam logic [2:0] ST_SSRC_CHG   = 3'd5;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd6;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int unsigned START_CODE_LEN = 5;

    // work for the back end, produced by one input item
    typedef struct packed {
        logic        start;
        logic        data;
        logic        stat;
        logic [7:0]  byte_val;
        logic [2:0]  status;
        logic [31:0] pts;
        logic [4:0]  nal_type;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/rtp_h264_depacketizer.sv]
// RTP H.264 depacketizer: RTP packet bytes in, Annex B byte stream and
// per-packet status out (single NAL units and FU-A fragments).
// input channel: in_valid/in_stall with data_byte, first_byte, last_byte;
// one packet byte is taken per cycle while the 4-entry item queue has room.
// output channel: out_valid/out_stall; kind 0 carries a stream byte, kind 1
// a packet status; run_end marks the last result caused by one input byte.
// config: cfg_write with cfg_index 0 = payload type, 1 = extension skip length;
// the user writes these only while the block is idle, which it does not enforce.
// path: an accepted input byte's item is queued, then registered at the output.
// throughput: 1 input byte per cycle; the back end emits 1 result per cycle
// unless the receiver stalls, so a NAL start (start code + header, plus status
// on a last byte) gives up to 6 results; the queue holds off input as it drains.
// reset: parser idle, sequence/ssrc tracking cleared, queue and output
// register empty, config back to payload type 96 and skip length 16.
// receiver stall: the output register holds; the queue fills and then
// in_stall rises until results are taken again.
`default_nettype none
module rtp_h264_depacketizer
    import rtpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic [31:0]      frame_pts,
    output logic [4:0]       nal_type,
    output logic             run_end
);

    cmd_t               cmd;
    cmd_t               head;
    logic               push;
    logic               pop;
    logic               q_empty;
    logic               q_full;
    logic [Q_CNT_W-1:0] q_count;
    logic               in_accept;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    rtpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .cmd        (cmd),
        .push       (push)
    );

    rtpd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    rtpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .status    (status),
        .frame_pts (frame_pts),
        .nal_type  (nal_type),
        .run_end   (run_end)
    );

    // a status result always closes the run of its item
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> run_end)
        else $error("status result without run_end");

    // status results carry no stream byte
    a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> out_byte == 8'h00)
        else $error("status result with nonzero byte");

    // queue level rises by one on a push without a pop
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> q_count == $past(q_count) + 1'b1)
        else $error("queue level mismatch");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

endmodule
`default_nettype wire

[rtl/rtpd_front.sv]
`default_nettype none
module rtpd_front
    import rtpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_byte,
    input  wire logic       last_byte,
    output cmd_t            cmd,
    output logic            push
);

    logic [6:0]  pt_reg;
    logic [7:0]  ext_reg;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] exp_reg, exp_next;
    logic [31:0] known_reg, known_next;
    logic [7:0]  skip_reg, skip_next;
    logic        rej_reg, rej_next;
    logic [2:0]  rcode_reg, rcode_next;
    logic [7:0]  frag_reg, frag_next;
    logic [31:0] cur_pts_reg, cur_pts_next;
    logic [4:0]  cur_type_reg, cur_type_next;

    logic [3:0]  pos_w;
    logic [15:0] exp_inc;
    logic [7:0]  hdr_w;
    logic [2:0]  st_w;

    always_comb
    begin
        pos_next      = pos_reg;
        flags_next    = flags_reg;
        seq_next      = seq_reg;
        ts_next       = ts_reg;
        src_next      = src_reg;
        exp_next      = exp_reg;
        known_next    = known_reg;
        skip_next     = skip_reg;
        rej_next      = rej_reg;
        rcode_next    = rcode_reg;
        frag_next     = frag_reg;
        cur_pts_next  = cur_pts_reg;
        cur_type_next = cur_type_reg;
        exp_inc       = exp_reg + 16'd1;
        pos_w         = first_byte ? POS_IDLE : pos_reg;
        hdr_w         = data_byte;
        st_w          = ST_FRAME_DONE;
        cmd           = '0;
        push          = 1'b0;

        if (in_accept && (first_byte || pos_reg != POS_IDLE))
        begin
            if (first_byte)
            begin
                rej_next   = 1'b0;
                rcode_next = ST_FRAME_DONE;
            end

            if (pos_w < POS_SKIP)
            begin
                priority if (pos_w == 4'd0)
                    flags_next = {data_byte, 8'h00};
                else if (pos_w == 4'd1)
                    flags_next = {flags_reg[15:8], data_byte};
                else if (pos_w < 4'd4)
                    seq_next = {seq_reg[7:0], data_byte};
                else if (pos_w < 4'd8)
                    ts_next = {ts_reg[23:0], data_byte};
                else
                    src_next = {src_reg[23:0], data_byte};
                pos_next = pos_w + 4'd1;

                if (pos_w == POS_HDR_END)
                begin
                    // header complete: checks in order version, type, sequence, source
                    rej_next   = 1'b0;
                    rcode_next = ST_FRAME_DONE;
                    priority if (flags_reg[15:14] != RTP_VERSION)
                    begin
                        rej_next   = 1'b1;
                        rcode_next = ST_BAD_VER;
                    end
                    else if (flags_reg[6:0] != pt_reg)
                    begin
                        rej_next   = 1'b1;
                        rcode_next = ST_BAD_TYPE;
                    end
                    else if (exp_reg == 16'd0 && known_reg == 32'd0)
                    begin
                        exp_next   = seq_reg;
                        known_next = src_next;
                    end
                    else if (seq_reg != exp_inc)
                    begin
                        exp_next      = seq_reg;
                        cur_pts_next  = 32'd0;
                        cur_type_next = 5'd0;
                        rej_next      = 1'b1;
                        rcode_next    = ST_SEQ_GAP;
                    end
                    else
                    begin
                        exp_next = exp_inc;
                        if (src_next != known_reg)
                        begin
                            known_next = src_next;
                            rej_next   = 1'b1;
                            rcode_next = ST_SSRC_CHG;
                        end
                    end

                    if (flags_reg[12] && ext_reg != 8'd0)
                    begin
                        skip_next = ext_reg;
                        pos_next  = POS_SKIP;
                    end
                    else
                    begin
                        skip_next = 8'd0;
                        pos_next  = POS_NAL;
                    end
                end
            end
            else if (!rej_next)
            begin
                unique case (pos_w)
                    POS_SKIP:
                    begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_next == 8'd0)
                            pos_next = POS_NAL;
                    end
                    POS_NAL:
                    begin
                        frag_next = data_byte;
                        if (data_byte[4:0] == FU_A_TYPE)
                            pos_next = POS_FU;
                        else
                        begin
                            cmd.start = 1'b1;
                            pos_next  = POS_PAYLOAD;
                        end
                    end
                    POS_FU:
                    begin
                        hdr_w = {frag_reg[7:5], data_byte[4:0]};
                        cmd.start = data_byte[7];
                        pos_next  = POS_PAYLOAD;
                    end
                    default:
                    begin
                        cmd.data = 1'b1;
                    end
                endcase
            end

            if (cmd.start)
            begin
                cur_pts_next  = ts_reg;
                cur_type_next = hdr_w[4:0];
            end
            cmd.byte_val = hdr_w;

            if (last_byte)
            begin
                priority if (pos_next >= POS_SKIP && rej_next)
                    st_w = rcode_next;
                else if (pos_next != POS_PAYLOAD)
                    st_w = ST_TOO_SHORT;
                else if (flags_next[7])
                    st_w = ST_FRAME_DONE;
                else
                    st_w = ST_FRAME_CONT;
                cmd.stat   = 1'b1;
                cmd.status = st_w;
                pos_next   = POS_IDLE;
                rej_next   = 1'b0;
                rcode_next = ST_FRAME_DONE;
                skip_next  = 8'd0;
            end

            // results of this item report the frame state before an end-of-frame clear
            cmd.pts      = cur_pts_next;
            cmd.nal_type = cur_type_next;
            if (last_byte && st_w == ST_FRAME_DONE)
            begin
                cur_pts_next  = 32'd0;
                cur_type_next = 5'd0;
            end
            push = cmd.start | cmd.data | cmd.stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg       <= PT_RESET;
            ext_reg      <= EXT_RESET;
            pos_reg      <= POS_IDLE;
            flags_reg    <= '0;
            seq_reg      <= '0;
            ts_reg       <= '0;
            src_reg      <= '0;
            exp_reg      <= '0;
            known_reg    <= '0;
            skip_reg     <= '0;
            rej_reg      <= 1'b0;
            rcode_reg    <= ST_FRAME_DONE;
            frag_reg     <= '0;
            cur_pts_reg  <= '0;
            cur_type_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_PAYLOAD_TYPE)
                pt_reg <= cfg_data[6:0];
            if (cfg_write && cfg_index == CFG_EXT_SKIP)
                ext_reg <= cfg_data;
            pos_reg      <= pos_next;
            flags_reg    <= flags_next;
            seq_reg      <= seq_next;
            ts_reg       <= ts_next;
            src_reg      <= src_next;
            exp_reg      <= exp_next;
            known_reg    <= known_next;
            skip_reg     <= skip_next;
            rej_reg      <= rej_next;
            rcode_reg    <= rcode_next;
            frag_reg     <= frag_next;
            cur_pts_reg  <= cur_pts_next;
            cur_type_reg <= cur_type_next;
        end
    end

endmodule
`default_nettype wire

[rtl/rtpd_fifo.sv]
`default_nettype none
module rtpd_fifo
    import rtpd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire cmd_t         push_cmd,
    input  wire logic         pop,
    output cmd_t              head,
    output logic              empty,
    output logic              full,
    output logic [Q_CNT_W-1:0] count
);

    cmd_t                 mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign head  = mem[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/rtpd_back.sv]
`default_nettype none
module rtpd_back
    import rtpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        head,
    input  wire logic        empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic [31:0]      frame_pts,
    output logic [4:0]       nal_type,
    output logic             run_end
);

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] pts_reg, pts_next;
    logic [4:0]  type_reg, type_next;
    logic        end_reg, end_next;

    logic [2:0]  n_res;
    logic        advance;
    logic        is_last;

    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        n_res = (head.start ? 3'(START_CODE_LEN) : 3'd0) + 3'(head.data) + 3'(head.stat);
        is_last = idx_reg == n_res - 3'd1;

        idx_next    = idx_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        pts_next    = pts_reg;
        type_next   = type_reg;
        end_next    = end_reg;
        pop         = 1'b0;

        if (advance)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                // status is always the final result of an item
                kind_next   = (is_last && head.stat) ? KIND_STATUS : KIND_BYTE;
                status_next = (is_last && head.stat) ? head.status : ST_FRAME_DONE;
                if (is_last && head.stat)
                    byte_next = 8'h00;
                else if (head.start && idx_reg < 3'd3)
                    byte_next = 8'h00;
                else if (head.start && idx_reg == 3'd3)
                    byte_next = 8'h01;
                else
                    byte_next = head.byte_val;
                pts_next  = head.pts;
                type_next = head.nal_type;
                end_next  = is_last;
                if (is_last)
                begin
                    pop      = 1'b1;
                    idx_next = 3'd0;
                end
                else
                    idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        pts_reg    <= pts_next;
        type_reg   <= type_next;
        end_reg    <= end_next;
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign frame_pts = pts_reg;
    assign nal_type  = type_reg;
    assign run_end   = end_reg;

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench
    import rtpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
        logic       last;
    } rtp_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [2:0]  status;
        logic [31:0] pts;
        logic [4:0]  nal;
        logic        run_end;
    } annexb_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_PAYLOAD_TYPE;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] frame_pts;
    logic [4:0]  nal_type;
    logic        run_end;

    rtp_h264_depacketizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .status     (status),
        .frame_pts  (frame_pts),
        .nal_type   (nal_type),
        .run_end    (run_end)
    );

    rtp_item_t      rtp_bytes[$];
    annexb_result_t annexb_q[$];
    rtp_item_t      on_wire;
    int             send_idle = 0;
    int             recv_stall = 0;
    int             queued_total = 0;
    int             taken_total = 0;
    int             errors = 0;

    // register copies
    logic [6:0]  pt_cfg = PT_RESET;
    logic [7:0]  ext_cfg = EXT_RESET;

    // parser and stream tracking state
    logic [3:0]  pos = POS_IDLE;
    logic [15:0] hdr_flags = '0;
    logic [15:0] seq_in = '0;
    logic [31:0] ts_in = '0;
    logic [31:0] ssrc_in = '0;
    logic [15:0] seq_expected = '0;
    logic [31:0] ssrc_known = '0;
    logic [7:0]  skip_left = '0;
    logic        rejected = 1'b0;
    logic [2:0]  reject_status = '0;
    logic [7:0]  fu_indicator = '0;
    logic [31:0] frame_ts = '0;
    logic [4:0]  frame_nal = '0;

    // stream position for generated packets
    logic [15:0] gen_seq;
    logic [31:0] gen_ssrc;

    initial forever #2 clk = ~clk;

    task automatic emit_byte(input logic [7:0] v);
        annexb_result_t r;
        r = '{kind: KIND_BYTE, value: v, status: '0, pts: frame_ts, nal: frame_nal,
              run_end: 1'b0};
        annexb_q.push_back(r);
    endtask

    task automatic emit_status(input logic [2:0] st);
        annexb_result_t r;
        r = '{kind: KIND_STATUS, value: '0, status: st, pts: frame_ts, nal: frame_nal,
              run_end: 1'b0};
        annexb_q.push_back(r);
    endtask

    task automatic nal_start(input logic [7:0] hdr);
        frame_ts = ts_in;
        frame_nal = hdr[4:0];
        emit_byte(8'h00);
        emit_byte(8'h00);
        emit_byte(8'h00);
        emit_byte(8'h01);
        emit_byte(hdr);
    endtask

    task automatic header_checks();
        rejected = 1'b0;
        reject_status = '0;
        if (hdr_flags[15:14] != RTP_VERSION) begin
            rejected = 1'b1;
            reject_status = ST_BAD_VER;
        end else if (hdr_flags[6:0] != pt_cfg) begin
            rejected = 1'b1;
            reject_status = ST_BAD_TYPE;
        end else if (seq_expected == 0 && ssrc_known == 0) begin
            seq_expected = seq_in;
            ssrc_known = ssrc_in;
        end else begin
            seq_expected = seq_expected + 16'd1;
            if (seq_in != seq_expected) begin
                // resync, partial frame is dropped
                seq_expected = seq_in;
                frame_ts = '0;
                frame_nal = '0;
                rejected = 1'b1;
                reject_status = ST_SEQ_GAP;
            end else if (ssrc_in != ssrc_known) begin
                ssrc_known = ssrc_in;
                rejected = 1'b1;
                reject_status = ST_SSRC_CHG;
            end
        end
        if (hdr_flags[12] && ext_cfg != 0) begin
            skip_left = ext_cfg;
            pos = POS_SKIP;
        end else begin
            skip_left = '0;
            pos = POS_NAL;
        end
    endtask

    task automatic depacketize(input rtp_item_t it);
        int         n_before;
        logic [2:0] st;
        logic [7:0] b;
        n_before = annexb_q.size();
        b = it.value;
        if (it.first) begin
            pos = POS_IDLE;
            rejected = 1'b0;
            reject_status = '0;
        end else if (pos == POS_IDLE) begin
            return;
        end

        if (pos <= POS_HDR_END) begin
            if (pos == 0)
                hdr_flags = {b, 8'h00};
            else if (pos == 1)
                hdr_flags[7:0] = b;
            else if (pos < 4)
                seq_in = {seq_in[7:0], b};
            else if (pos < 8)
                ts_in = {ts_in[23:0], b};
            else
                ssrc_in = {ssrc_in[23:0], b};
            pos = pos + 4'd1;
            if (pos == POS_SKIP)
                header_checks();
        end else if (rejected) begin
            // dropped packet, payload ignored
        end else if (pos == POS_SKIP) begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 0)
                pos = POS_NAL;
        end else if (pos == POS_NAL) begin
            fu_indicator = b;
            if (b[4:0] == FU_A_TYPE) begin
                pos = POS_FU;
            end else begin
                nal_start(b);
                pos = POS_PAYLOAD;
            end
        end else if (pos == POS_FU) begin
            if (b[7])
                nal_start({fu_indicator[7:5], b[4:0]});
            pos = POS_PAYLOAD;
        end else begin
            emit_byte(b);
        end

        if (it.last) begin
            if (pos >= POS_SKIP && rejected)
                st = reject_status;
            else if (pos != POS_PAYLOAD)
                st = ST_TOO_SHORT;
            else
                st = hdr_flags[7] ? ST_FRAME_DONE : ST_FRAME_CONT;
            emit_status(st);
            if (st == ST_FRAME_DONE) begin
                frame_ts = '0;
                frame_nal = '0;
            end
            pos = POS_IDLE;
            rejected = 1'b0;
            reject_status = '0;
            skip_left = '0;
        end

        if (annexb_q.size() > n_before)
            annexb_q[annexb_q.size() - 1].run_end = 1'b1;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            first_byte <= 1'b0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                depacketize(on_wire);
                taken_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (rtp_bytes.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    on_wire = rtp_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= on_wire.value;
                    first_byte <= on_wire.first;
                    last_byte <= on_wire.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin : check_results
        annexb_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (annexb_q.size() == 0)
            begin
                $error("result with none expected: kind %0d byte %02h status %0d",
                       kind, out_byte, status);
                errors++;
            end
            else
            begin
                want = annexb_q.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    errors++;
                end
                if (out_byte !== want.value)
                begin
                    $error("out_byte: expected %02h, got %02h", want.value, out_byte);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (frame_pts !== want.pts)
                begin
                    $error("frame_pts: expected %08h, got %08h", want.pts, frame_pts);
                    errors++;
                end
                if (nal_type !== want.nal)
                begin
                    $error("nal_type: expected %0d, got %0d", want.nal, nal_type);
                    errors++;
                end
                if (run_end !== want.run_end)
                begin
                    $error("run_end: expected %0d, got %0d", want.run_end, run_end);
                    errors++;
                end
            end
        end
    end

    task automatic set_register(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PAYLOAD_TYPE)
            pt_cfg = val[6:0];
        else
            ext_cfg = val;
    endtask

    // wait until every item is taken and every result seen, then let the pipe drain
    task automatic settle();
        do
            @(posedge clk);
        while (taken_total != queued_total || annexb_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    // cut = 0 keeps the whole packet; closed = 0 leaves off the last mark
    task automatic queue_packet(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [15:0] seq, input logic [31:0] ssrc,
                                input logic [7:0] nal, input logic [7:0] fu,
                                input int n_payload, input int cut, input bit closed);
        logic [7:0]  pkt[$];
        logic [95:0] hdr;
        logic [31:0] ts;
        rtp_item_t   it;
        int          n;
        int          i;
        ts = $urandom;
        hdr = {b0, b1, seq, ts, ssrc};
        for (i = 0; i < 12; i++)
            pkt.push_back(hdr[95 - 8 * i -: 8]);
        if (b0[4])
            repeat (ext_cfg) pkt.push_back(8'($urandom_range(255)));
        pkt.push_back(nal);
        if (nal[4:0] == FU_A_TYPE)
            pkt.push_back(fu);
        repeat (n_payload) pkt.push_back(8'($urandom_range(255)));
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (i = 0; i < n; i++)
        begin
            it.value = pkt[i];
            it.first = (i == 0);
            it.last = closed && (i == n - 1);
            rtp_bytes.push_back(it);
        end
        queued_total += n;
    endtask

    task automatic random_packet(input bit may_fault);
        int          pick;
        int          npay;
        int          cut;
        int          head_len;
        bit          closed;
        bit          good;
        logic [1:0]  ver;
        logic        x;
        logic [6:0]  pt;
        logic [15:0] seq;
        logic [31:0] ssrc;
        logic [7:0]  nal;
        logic [7:0]  fu;
        logic        pad;
        logic [3:0]  cc;
        pick = may_fault ? $urandom_range(99) : 99;
        ver = RTP_VERSION;
        pt = pt_cfg;
        seq = gen_seq;
        ssrc = gen_ssrc;
        x = (ext_cfg > 32) ? ($urandom_range(5) == 0) : ($urandom_range(3) == 0);
        pad = 1'($urandom_range(1));
        cc = 4'($urandom_range(15));
        nal = 8'($urandom_range(255));
        if ($urandom_range(2) == 0)
            nal[4:0] = FU_A_TYPE;
        else if (nal[4:0] == FU_A_TYPE)
            nal[0] = 1'b1;
        fu = 8'($urandom_range(255));
        fu[7] = ($urandom_range(4) != 0);
        npay = $urandom_range(5);
        cut = 0;
        closed = 1'b1;
        good = 1'b1;
        head_len = 12 + ((x && ext_cfg != 0) ? ext_cfg : 0)
                 + ((nal[4:0] == FU_A_TYPE) ? 1 : 0);
        if (pick < 8)
        begin
            ver = 2'($urandom_range(2));
            if (ver == RTP_VERSION)
                ver = 2'd3;
            good = 1'b0;
        end
        else if (pick < 16)
        begin
            pt = pt_cfg ^ 7'($urandom_range(1, 127));
            good = 1'b0;
        end
        else if (pick < 22)
        begin
            seq = gen_seq + 16'($urandom_range(2, 1000));
            gen_seq = seq;
        end
        else if (pick < 28)
        begin
            ssrc = $urandom;
            gen_ssrc = ssrc;
        end
        else if (pick < 38)
        begin
            // ends inside the header, the extension or before the nal header
            cut = $urandom_range(1, head_len);
        end
        else if (pick < 44)
        begin
            // abandoned: the next first mark restarts the parser
            cut = $urandom_range(1, head_len + 1 + npay);
            closed = 1'b0;
        end
        if (cut != 0 && cut < 12)
            good = 1'b0;
        queue_packet({ver, pad, x, cc}, {1'($urandom_range(1)), pt}, seq, ssrc,
                     nal, fu, npay, cut, closed);
        if (good)
            gen_seq = gen_seq + 16'd1;
        if (closed && $urandom_range(5) == 0)
        begin
            // stray byte between packets
            rtp_bytes.push_back('{value: 8'($urandom_range(255)), first: 1'b0,
                                  last: 1'($urandom_range(1))});
            queued_total++;
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_start;
        gen_ssrc = 32'hFFFF_FFFF;
        gen_seq = 16'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    set_register(CFG_PAYLOAD_TYPE, 8'h7F);
                    set_register(CFG_EXT_SKIP, 8'd0);
                    send_idle = 70;
                    recv_stall = 0;
                end
                2: begin
                    set_register(CFG_PAYLOAD_TYPE, 8'h80);
                    set_register(CFG_EXT_SKIP, 8'd255);
                    send_idle = 0;
                    recv_stall = 70;
                end
                3: begin
                    set_register(CFG_PAYLOAD_TYPE, 8'($urandom_range(255)));
                    set_register(CFG_EXT_SKIP, 8'd1);
                    send_idle = 29;
                    recv_stall = 29;
                end
                default: begin
                    set_register(CFG_PAYLOAD_TYPE, {1'b0, PT_RESET});
                    set_register(CFG_EXT_SKIP, 8'($urandom_range(2, 40)));
                    send_idle = 0;
                    recv_stall = 0;
                end
            endcase

            if (phase == 0)
            begin
                // stray byte while idle, then a one-byte packet
                rtp_bytes.push_back('{value: 8'hFF, first: 1'b0, last: 1'b1});
                rtp_bytes.push_back('{value: 8'h80, first: 1'b1, last: 1'b1});
                queued_total += 2;
                // latches sequence and source, single nal of type 31, frame continues
                queue_packet({RTP_VERSION, 1'b1, 1'b0, 4'hF}, {1'b0, PT_RESET},
                             16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00, 0, 0, 1'b1);
                // sequence wraps to zero, fu-a start fragment, marker ends the frame
                queue_packet({RTP_VERSION, 1'b0, 1'b0, 4'h0}, {1'b1, PT_RESET},
                             16'h0000, 32'hFFFF_FFFF, {3'b011, FU_A_TYPE}, 8'h85, 1, 0,
                             1'b1);
            end

            phase_start = queued_total;
            while (queued_total - phase_start < 15)
                random_packet(1'b1);
            random_packet(1'b0);
            settle();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[rtp_h264_depacketizer.f]
rtl/rtpd_pkg.sv
rtl/rtpd_front.sv
rtl/rtpd_fifo.sv
rtl/rtpd_back.sv
rtl/rtp_h264_depacketizer.sv
tb/testbench.sv
